FILE: rtl/cpu_6502_subset_bus_cycle_core_macros.svh
// assertion helpers for the bus cycle core
`ifndef CPU_6502_SUBSET_BUS_CYCLE_CORE_MACROS_SVH
`define CPU_6502_SUBSET_BUS_CYCLE_CORE_MACROS_SVH
// property checked on every rising clock edge outside reset
`define C65_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define C65_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/c65_pkg.sv
package c65_pkg;
   localparam logic [1:0] KIND_IDLE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam logic [3:0] OP_ILL = 4'd0;
   localparam logic [3:0] OP_ADC = 4'd1;
   localparam logic [3:0] OP_LDA = 4'd2;
   localparam logic [3:0] OP_LDX = 4'd3;
   localparam logic [3:0] OP_LDY = 4'd4;
   localparam logic [3:0] OP_STA = 4'd5;
   localparam logic [3:0] OP_JMP = 4'd6;
   localparam logic [3:0] OP_CLC = 4'd7;
   localparam logic [3:0] OP_SEC = 4'd8;
   localparam logic [3:0] OP_NOP = 4'd9;

   localparam logic [3:0] M_IMP = 4'd0;
   localparam logic [3:0] M_IMM = 4'd1;
   localparam logic [3:0] M_ZP  = 4'd2;
   localparam logic [3:0] M_ZPX = 4'd3;
   localparam logic [3:0] M_ZPY = 4'd4;
   localparam logic [3:0] M_ABS = 4'd5;
   localparam logic [3:0] M_ABX = 4'd6;
   localparam logic [3:0] M_ABY = 4'd7;
   localparam logic [3:0] M_IZX = 4'd8;
   localparam logic [3:0] M_IZY = 4'd9;
   localparam logic [3:0] M_IND = 4'd10;

   localparam logic [3:0] STEP_DONE  = 4'd7;
   localparam logic [3:0] STEP_RESET = 4'd8;

   localparam logic [15:0] VEC_LO = 16'hFFFC;
   localparam logic [15:0] VEC_HI = 16'hFFFD;
   localparam logic [7:0] FLAGS_RESET = 8'h34;
   localparam logic [7:0] FLAG_C = 8'h01;
   localparam logic [7:0] FLAG_Z = 8'h02;
   localparam logic [7:0] FLAG_I = 8'h04;
   localparam logic [7:0] FLAG_V = 8'h40;
   localparam logic [7:0] FLAG_N = 8'h80;
   localparam logic [15:0] PAGE_MASK = 16'hFF00;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] mode;
   } decode_type;

   typedef struct packed {
      logic [7:0]  a;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  sp;
      logic [7:0]  p;
      logic [15:0] pc;
      logic [15:0] ea;
      logic [15:0] pt;
      logic [7:0]  opc;
      logic [3:0]  step;
   } cpu_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic        fetch;
      logic        ill;
   } bus_type;
endpackage

FILE: rtl/c65_decode.sv
module c65_decode (
   input  logic [7:0]          opcode,
   output c65_pkg::decode_type dec
);
   always_comb begin
      dec.op = c65_pkg::OP_ILL;
      dec.mode = c65_pkg::M_IMP;
      unique case (opcode)
         8'h18: dec.op = c65_pkg::OP_CLC;
         8'h38: dec.op = c65_pkg::OP_SEC;
         8'hEA: dec.op = c65_pkg::OP_NOP;
         8'h4C: begin dec.op = c65_pkg::OP_JMP; dec.mode = c65_pkg::M_ABS; end
         8'h6C: begin dec.op = c65_pkg::OP_JMP; dec.mode = c65_pkg::M_IND; end
         8'h61: begin dec.op = c65_pkg::OP_ADC; dec.mode = c65_pkg::M_IZX; end
         8'h65: begin dec.op = c65_pkg::OP_ADC; dec.mode = c65_pkg::M_ZP;  end
         8'h69: begin dec.op = c65_pkg::OP_ADC; dec.mode = c65_pkg::M_IMM; end
         8'h6D: begin dec.op = c65_pkg::OP_ADC; dec.mode = c65_pkg::M_ABS; end
         8'h71: begin dec.op = c65_pkg::OP_ADC; dec.mode = c65_pkg::M_IZY; end
         8'h75: begin dec.op = c65_pkg::OP_ADC; dec.mode = c65_pkg::M_ZPX; end
         8'h79: begin dec.op = c65_pkg::OP_ADC; dec.mode = c65_pkg::M_ABY; end
         8'h7D: begin dec.op = c65_pkg::OP_ADC; dec.mode = c65_pkg::M_ABX; end
         8'h81: begin dec.op = c65_pkg::OP_STA; dec.mode = c65_pkg::M_IZX; end
         8'h85: begin dec.op = c65_pkg::OP_STA; dec.mode = c65_pkg::M_ZP;  end
         8'h8D: begin dec.op = c65_pkg::OP_STA; dec.mode = c65_pkg::M_ABS; end
         8'h91: begin dec.op = c65_pkg::OP_STA; dec.mode = c65_pkg::M_IZY; end
         8'h95: begin dec.op = c65_pkg::OP_STA; dec.mode = c65_pkg::M_ZPX; end
         8'h99: begin dec.op = c65_pkg::OP_STA; dec.mode = c65_pkg::M_ABY; end
         8'h9D: begin dec.op = c65_pkg::OP_STA; dec.mode = c65_pkg::M_ABX; end
         8'hA0: begin dec.op = c65_pkg::OP_LDY; dec.mode = c65_pkg::M_IMM; end
         8'hA1: begin dec.op = c65_pkg::OP_LDA; dec.mode = c65_pkg::M_IZX; end
         8'hA2: begin dec.op = c65_pkg::OP_LDX; dec.mode = c65_pkg::M_IMM; end
         8'hA4: begin dec.op = c65_pkg::OP_LDY; dec.mode = c65_pkg::M_ZP;  end
         8'hA5: begin dec.op = c65_pkg::OP_LDA; dec.mode = c65_pkg::M_ZP;  end
         8'hA6: begin dec.op = c65_pkg::OP_LDX; dec.mode = c65_pkg::M_ZP;  end
         8'hA9: begin dec.op = c65_pkg::OP_LDA; dec.mode = c65_pkg::M_IMM; end
         8'hAC: begin dec.op = c65_pkg::OP_LDY; dec.mode = c65_pkg::M_ABS; end
         8'hAD: begin dec.op = c65_pkg::OP_LDA; dec.mode = c65_pkg::M_ABS; end
         8'hAE: begin dec.op = c65_pkg::OP_LDX; dec.mode = c65_pkg::M_ABS; end
         8'hB1: begin dec.op = c65_pkg::OP_LDA; dec.mode = c65_pkg::M_IZY; end
         8'hB4: begin dec.op = c65_pkg::OP_LDY; dec.mode = c65_pkg::M_ZPX; end
         8'hB5: begin dec.op = c65_pkg::OP_LDA; dec.mode = c65_pkg::M_ZPX; end
         8'hB6: begin dec.op = c65_pkg::OP_LDX; dec.mode = c65_pkg::M_ZPY; end
         8'hB9: begin dec.op = c65_pkg::OP_LDA; dec.mode = c65_pkg::M_ABY; end
         8'hBC: begin dec.op = c65_pkg::OP_LDY; dec.mode = c65_pkg::M_ABX; end
         8'hBD: begin dec.op = c65_pkg::OP_LDA; dec.mode = c65_pkg::M_ABX; end
         8'hBE: begin dec.op = c65_pkg::OP_LDX; dec.mode = c65_pkg::M_ABY; end
         default: ;
      endcase
   end
endmodule

FILE: rtl/cpu_6502_subset_bus_cycle_core.sv
// One request is one bus cycle: it carries the byte read by the access issued
// in the previous response (or a reset pulse), and the core answers with
// exactly one response, the next bus access (idle, read or write) plus the
// A, X, Y, P and PC registers after that cycle. A request is taken in every
// clock while the response register is empty or being drained, so the core
// runs one bus cycle per clock; all next-state logic sits between the
// architectural registers and the response register. After reset the core
// runs the usual start-up sequence (idle bus cycles, then reads of 0xFFFC and
// 0xFFFD) before the first opcode fetch.
`include "cpu_6502_subset_bus_cycle_core_macros.svh"
module cpu_6502_subset_bus_cycle_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_read_data,
   input  logic        req_start_reset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_bus_kind,
   output logic [15:0] rsp_bus_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_opcode_fetch,
   output logic        rsp_illegal_opcode,
   output logic [7:0]  rsp_acc_out,
   output logic [7:0]  rsp_x_out,
   output logic [7:0]  rsp_y_out,
   output logic [7:0]  rsp_flags_out,
   output logic [15:0] rsp_pc_out
);
   c65_pkg::cpu_state_type st_ff, st_in;
   c65_pkg::bus_type       bus_ff, bus_in;
   logic                   vld_ff, vld_in;
   c65_pkg::decode_type    dec;
   logic [7:0]             opc_now;
   logic [3:0]             s;
   logic                   take;
   logic [7:0]             d;
   logic [8:0]             sum;
   logic [7:0]             res;
   logic [15:0]            base;
   logic [15:0]            idx_ea;
   logic [7:0]             idx;

   assign take      = req_valid && req_ready;
   assign req_ready = !vld_ff || rsp_ready;
   assign d         = req_read_data;
   assign s         = req_start_reset ? c65_pkg::STEP_RESET : st_ff.step;
   // the opcode byte arrives on step zero
   assign opc_now   = (s == 4'd0) ? d : st_ff.opc;

   c65_decode u_dec (.opcode(opc_now), .dec(dec));

   always_comb begin
      st_in  = st_ff;
      bus_in = '0;
      sum    = 9'd0;
      res    = 8'd0;
      base   = 16'd0;
      idx    = 8'd0;
      idx_ea = 16'd0;
      st_in.opc = opc_now;
      if (s >= c65_pkg::STEP_RESET) begin
         // start-up sequence
         st_in.step = s + 4'd1;
         case (s) inside
            4'd8: st_in.p = st_ff.p | c65_pkg::FLAG_I;
            4'd11, 4'd12: st_in.sp = st_ff.sp - 8'd1;
            4'd13: begin
               st_in.sp = st_ff.sp - 8'd1;
               bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = c65_pkg::VEC_LO;
            end
            4'd14: begin
               st_in.pt = {8'd0, d};
               bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = c65_pkg::VEC_HI;
            end
            4'd15: begin
               bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = {d, st_ff.pt[7:0]};
               bus_in.fetch = 1'b1;
               st_in.pc = {d, st_ff.pt[7:0]} + 16'd1;
               st_in.step = 4'd0;
            end
            default: ;
         endcase
      end else if (s == c65_pkg::STEP_DONE) begin
         // retire: any read operand is on the data bus
         case (dec.op) inside
            c65_pkg::OP_ADC: begin
               sum = {1'b0, st_ff.a} + {1'b0, d} + {8'd0, st_ff.p[0]};
               res = sum[7:0];
               st_in.a = res;
               st_in.p[0] = sum[8];
               st_in.p[6] = ~(st_ff.a[7] ^ d[7]) & (st_ff.a[7] ^ res[7]);
               st_in.p[1] = (res == 8'd0);
               st_in.p[7] = res[7];
            end
            c65_pkg::OP_LDA, c65_pkg::OP_LDX, c65_pkg::OP_LDY: begin
               if (dec.op == c65_pkg::OP_LDA) st_in.a = d;
               if (dec.op == c65_pkg::OP_LDX) st_in.x = d;
               if (dec.op == c65_pkg::OP_LDY) st_in.y = d;
               st_in.p[1] = (d == 8'd0);
               st_in.p[7] = d[7];
            end
            c65_pkg::OP_CLC: st_in.p[0] = 1'b0;
            c65_pkg::OP_SEC: st_in.p[0] = 1'b1;
            default: ;
         endcase
         bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = st_ff.pc; bus_in.fetch = 1'b1;
         st_in.pc = st_ff.pc + 16'd1;
         st_in.step = 4'd0;
      end else begin
         // final-access helper values
         idx = (dec.mode == c65_pkg::M_ABX) ? st_ff.x : st_ff.y;
         if (dec.mode == c65_pkg::M_IZY) begin
            base = {d, st_ff.ea[7:0]};
         end else begin
            base = {d, st_ff.pt[7:0]};
         end
         idx_ea = base + {8'd0, idx};
         if (dec.mode == c65_pkg::M_IMP) begin
            bus_in.ill = (dec.op == c65_pkg::OP_ILL);
            st_in.step = c65_pkg::STEP_DONE;
         end else if (dec.mode == c65_pkg::M_IMM) begin
            st_in.ea = st_ff.pc;
            bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = st_ff.pc;
            st_in.pc = st_ff.pc + 16'd1;
            st_in.step = c65_pkg::STEP_DONE;
         end else if (s == 4'd0) begin
            bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = st_ff.pc;
            st_in.pc = st_ff.pc + 16'd1;
            st_in.step = 4'd1;
         end else begin
            // final access at st_in.ea flagged by step 7 when reached
            case (dec.mode) inside
               c65_pkg::M_ZP: begin
                  st_in.ea = {8'd0, d};
                  st_in.step = c65_pkg::STEP_DONE;
               end
               c65_pkg::M_ZPX, c65_pkg::M_ZPY: begin
                  if (s == 4'd1) begin
                     st_in.ea = {8'd0, d + ((dec.mode == c65_pkg::M_ZPX) ? st_ff.x : st_ff.y)};
                     st_in.step = 4'd2;
                  end else st_in.step = c65_pkg::STEP_DONE;
               end
               c65_pkg::M_ABS, c65_pkg::M_ABX, c65_pkg::M_ABY, c65_pkg::M_IND: begin
                  if (s == 4'd1) begin
                     st_in.pt = {8'd0, d};
                     bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = st_ff.pc;
                     st_in.pc = st_ff.pc + 16'd1;
                     st_in.step = 4'd2;
                  end else if (s == 4'd2) begin
                     if (dec.mode == c65_pkg::M_ABS) begin
                        st_in.ea = base; st_in.step = c65_pkg::STEP_DONE;
                     end else if (dec.mode == c65_pkg::M_IND) begin
                        st_in.pt = base;
                        bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = base;
                        st_in.step = 4'd3;
                     end else begin
                        st_in.ea = idx_ea;
                        if (dec.op == c65_pkg::OP_STA ||
                            (idx_ea & c65_pkg::PAGE_MASK) != (base & c65_pkg::PAGE_MASK))
                           st_in.step = 4'd3;
                        else st_in.step = c65_pkg::STEP_DONE;
                     end
                  end else if (dec.mode == c65_pkg::M_IND && s == 4'd3) begin
                     st_in.ea = {8'd0, d};
                     bus_in.kind = c65_pkg::KIND_READ;
                     bus_in.addr = {st_ff.pt[15:8], st_ff.pt[7:0] + 8'd1};
                     st_in.step = 4'd4;
                  end else if (dec.mode == c65_pkg::M_IND) begin
                     st_in.ea = {d, st_ff.ea[7:0]};
                     st_in.step = c65_pkg::STEP_DONE;
                  end else st_in.step = c65_pkg::STEP_DONE;
               end
               c65_pkg::M_IZX: begin
                  if (s == 4'd1) begin
                     st_in.pt = {8'd0, d + st_ff.x}; st_in.step = 4'd2;
                  end else if (s == 4'd2) begin
                     bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = st_ff.pt;
                     st_in.step = 4'd3;
                  end else if (s == 4'd3) begin
                     st_in.ea = {8'd0, d};
                     bus_in.kind = c65_pkg::KIND_READ;
                     bus_in.addr = {8'd0, st_ff.pt[7:0] + 8'd1};
                     st_in.step = 4'd4;
                  end else begin
                     st_in.ea = {d, st_ff.ea[7:0]};
                     st_in.step = c65_pkg::STEP_DONE;
                  end
               end
               c65_pkg::M_IZY: begin
                  if (s == 4'd1) begin
                     st_in.pt = {8'd0, d};
                     bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = {8'd0, d};
                     st_in.step = 4'd2;
                  end else if (s == 4'd2) begin
                     st_in.ea = {8'd0, d};
                     bus_in.kind = c65_pkg::KIND_READ;
                     bus_in.addr = {8'd0, st_ff.pt[7:0] + 8'd1};
                     st_in.step = 4'd3;
                  end else if (s == 4'd3) begin
                     st_in.ea = idx_ea;
                     if (dec.op == c65_pkg::OP_STA ||
                         (idx_ea & c65_pkg::PAGE_MASK) != (base & c65_pkg::PAGE_MASK))
                        st_in.step = 4'd4;
                     else st_in.step = c65_pkg::STEP_DONE;
                  end else st_in.step = c65_pkg::STEP_DONE;
               end
               default: begin
                  bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = st_ff.pc;
                  bus_in.fetch = 1'b1;
                  st_in.pc = st_ff.pc + 16'd1;
                  st_in.step = 4'd0;
               end
            endcase
            // operand access once the address is settled
            if (st_in.step == c65_pkg::STEP_DONE) begin
               if (dec.op == c65_pkg::OP_JMP) begin
                  bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = st_in.ea;
                  bus_in.fetch = 1'b1;
                  st_in.pc = st_in.ea + 16'd1;
                  st_in.step = 4'd0;
               end else if (dec.op == c65_pkg::OP_STA) begin
                  bus_in.kind = c65_pkg::KIND_WRITE; bus_in.addr = st_in.ea;
                  bus_in.wdata = st_ff.a;
               end else begin
                  bus_in.kind = c65_pkg::KIND_READ; bus_in.addr = st_in.ea;
               end
            end
         end
      end
   end

   assign vld_in = take ? 1'b1 : (rsp_ready ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         st_ff  <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: 8'd0, p: c65_pkg::FLAGS_RESET,
                    pc: 16'd0, ea: 16'd0, pt: 16'd0, opc: 8'd0,
                    step: c65_pkg::STEP_RESET};
      end else begin
         vld_ff <= vld_in;
         if (take) st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) bus_ff <= bus_in;
   end

   assign rsp_valid          = vld_ff;
   assign rsp_bus_kind       = bus_ff.kind;
   assign rsp_bus_address    = bus_ff.addr;
   assign rsp_write_data     = bus_ff.wdata;
   assign rsp_opcode_fetch   = bus_ff.fetch;
   assign rsp_illegal_opcode = bus_ff.ill;
   assign rsp_acc_out        = st_ff.a;
   assign rsp_x_out          = st_ff.x;
   assign rsp_y_out          = st_ff.y;
   assign rsp_flags_out      = st_ff.p;
   assign rsp_pc_out         = st_ff.pc;

   `C65_ASSERT(a_fetch_read, clock, reset, !vld_ff || !bus_ff.fetch || bus_ff.kind == c65_pkg::KIND_READ, "fetch not a read")
   `C65_ASSERT(a_fetch_step, clock, reset, !vld_ff || !bus_ff.fetch || st_ff.step == 4'd0, "fetch without step zero")
   `C65_ASSERT(a_kind_legal, clock, reset, !vld_ff || bus_ff.kind != 2'd3, "bad bus kind")
   `C65_ASSERT_NEXT(a_reset_start, clock, reset, take && req_start_reset, st_ff.step == 4'd9 && st_ff.p[2], "reset start")
endmodule
